@@ rtl/core/sphere_frustum_cull_assert.svh @@
// Assertion macros used by the checker file of the sphere culling block.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef SPHERE_FRUSTUM_CULL_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the sphere frustum culling controller and
// datapath.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_WORDS = 4;
    localparam int PLANE_IDX_W = 3;
    localparam int COMP_IDX_W  = 2;
    localparam int ITER_W      = 6;
    localparam int SQRT_STEPS  = 25;
    localparam int DIV_STEPS   = 42;
    localparam int RAW_W       = 17;
    localparam int SQ_W        = 33;
    localparam int SUM_W       = 35;
    localparam int ROOT_W      = 51;
    localparam int LEN_W       = 25;
    localparam int NUM_W       = 42;

    localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = 3'(PLANE_COUNT - 1);
    localparam logic [COMP_IDX_W-1:0]  LAST_COMP  = 2'(PLANE_WORDS - 1);

    typedef enum logic [1:0] {
        REG_MATRIX_COL0 = 2'd0,
        REG_MATRIX_COL1 = 2'd1,
        REG_MATRIX_COL2 = 2'd2,
        REG_MATRIX_COL3 = 2'd3
    } reg_idx_t;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_CULL_MUL = 10'b0000000010,
        ST_CULL_ACC = 10'b0000000100,
        ST_RB_RAW   = 10'b0000001000,
        ST_RB_SUM   = 10'b0000010000,
        ST_RB_SQRT  = 10'b0000100000,
        ST_RB_DIVI  = 10'b0001000000,
        ST_RB_DIV   = 10'b0010000000,
        ST_RB_WR    = 10'b0100000000,
        ST_FIN      = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic                   load_in;
        logic                   cull_mul;
        logic                   raw_load;
        logic                   sqrt_init;
        logic                   sqrt_step;
        logic                   div_init;
        logic                   div_step;
        logic                   store_word;
        logic                   store_zero;
        logic [PLANE_IDX_W-1:0] plane;
        logic [COMP_IDX_W-1:0]  comp;
    } dp_cmd_t;

    typedef struct packed {
        logic reject;
        logic sum_zero;
    } dp_status_t;

endpackage

@@ rtl/core/sfc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_datapath
// Matrix registers, plane store, plane extraction, bit-serial square root
// and divider, and the sphere distance test.
// ----------------------------------------------------------------------------
module sfc_datapath import sfc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic signed [31:0] s_center_x,
    input  logic signed [31:0] s_center_y,
    input  logic signed [31:0] s_center_z,
    input  logic [30:0]        s_sphere_radius,
    input  dp_cmd_t            cmd,
    output dp_status_t         status
);

    logic [63:0]        matrix_reg [4];
    logic [31:0]        plane_reg [PLANE_COUNT][PLANE_WORDS];
    logic signed [31:0] center_reg [3];
    logic [30:0]        radius_reg;
    logic signed [63:0] prod_reg [3];
    logic signed [31:0] off_reg;
    logic signed [RAW_W-1:0] raw_reg [PLANE_WORDS];
    logic [SQ_W-1:0]    sq_reg [3];
    logic [ROOT_W-1:0]  x_reg, x_next;
    logic [ROOT_W-1:0]  res_reg, res_next;
    logic [48:0]        bit_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [LEN_W:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]   q_reg;
    logic               neg_reg;

    logic [1:0]              row;
    logic signed [RAW_W-1:0] raw [PLANE_WORDS];
    logic signed [33:0]      sq_full [3];
    logic [SUM_W-1:0]        sum;
    logic signed [50:0]      plane_dist;
    logic [ROOT_W-1:0]       trial_root;
    logic [LEN_W-1:0]        len;
    logic [LEN_W:0]          trial_rem;
    logic                    qbit;
    logic [RAW_W-1:0]        mag;
    logic [31:0]             sat;

    assign row = cmd.plane[2:1];
    assign len = res_reg[LEN_W-1:0];

    always_comb begin
        for (int j = 0; j < PLANE_WORDS; j++) begin
            logic signed [RAW_W-1:0] w;
            logic signed [RAW_W-1:0] e;
            w = RAW_W'($signed(matrix_reg[j][48 +: 16]));
            e = RAW_W'($signed(matrix_reg[j][16*row +: 16]));
            raw[j] = cmd.plane[0] ? (w + e) : (w - e);
        end
        for (int k = 0; k < 3; k++) begin
            sq_full[k] = raw[k] * raw[k];
        end
    end

    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_comb begin
        trial_root = res_reg + ROOT_W'(bit_reg);
        if (x_reg >= trial_root) begin
            x_next   = x_reg - trial_root;
            res_next = (res_reg >> 1) + ROOT_W'(bit_reg);
        end else begin
            x_next   = x_reg;
            res_next = res_reg >> 1;
        end
    end

    always_comb begin
        trial_rem = {rem_reg[LEN_W-1:0], num_reg[NUM_W-1]};
        qbit      = (trial_rem >= {1'b0, len});
        rem_next  = qbit ? (trial_rem - {1'b0, len}) : trial_rem;
    end

    assign mag = raw_reg[cmd.comp][RAW_W-1] ? RAW_W'(-raw_reg[cmd.comp])
                                            : RAW_W'(raw_reg[cmd.comp]);

    always_comb begin
        if (neg_reg) begin
            sat = (q_reg >= NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q_reg[31:0]);
        end else begin
            sat = (q_reg > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_reg[31:0];
        end
    end

    always_comb begin
        plane_dist = 51'(prod_reg[0] >>> 16) + 51'(prod_reg[1] >>> 16)
                   + 51'(prod_reg[2] >>> 16) + 51'(off_reg);
    end

    assign status.reject   = (plane_dist + $signed({20'd0, radius_reg})) < 0;
    assign status.sum_zero = (sum == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                matrix_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_MATRIX_COL0: matrix_reg[0] <= cfg_data;
                REG_MATRIX_COL1: matrix_reg[1] <= cfg_data;
                REG_MATRIX_COL2: matrix_reg[2] <= cfg_data;
                REG_MATRIX_COL3: matrix_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int k = 0; k < PLANE_WORDS; k++) begin
                    plane_reg[p][k] <= '0;
                end
            end
        end else if (cmd.store_zero) begin
            for (int k = 0; k < PLANE_WORDS; k++) begin
                plane_reg[cmd.plane][k] <= '0;
            end
        end else if (cmd.store_word) begin
            plane_reg[cmd.plane][cmd.comp] <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            center_reg[0] <= s_center_x;
            center_reg[1] <= s_center_y;
            center_reg[2] <= s_center_z;
            radius_reg    <= s_sphere_radius;
        end
        if (cmd.cull_mul) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= $signed(plane_reg[cmd.plane][k]) * center_reg[k];
            end
            off_reg <= $signed(plane_reg[cmd.plane][3]);
        end
        if (cmd.raw_load) begin
            for (int j = 0; j < PLANE_WORDS; j++) begin
                raw_reg[j] <= raw[j];
            end
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= SQ_W'(sq_full[k]);
            end
        end
        if (cmd.sqrt_init) begin
            x_reg   <= {sum, 16'd0};
            res_reg <= '0;
            bit_reg <= 49'd1 << 48;
        end else if (cmd.sqrt_step) begin
            x_reg   <= x_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init) begin
            num_reg <= {1'b0, mag, 24'd0} + NUM_W'(len >> 1);
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= raw_reg[cmd.comp][RAW_W-1];
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NUM_W-2:0], qbit};
        end
    end

endmodule

@@ rtl/core/sfc_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_controller
// State machine that sequences cull and rebuild transactions and holds the
// result register of the output channel.
// ----------------------------------------------------------------------------
module sfc_controller import sfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_visible,
    output logic [2:0] m_failing_plane,
    output logic [5:0] m_degenerate_mask,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t                 state_reg, state_next;
    logic [PLANE_IDX_W-1:0] plane_reg, plane_next;
    logic [COMP_IDX_W-1:0]  comp_reg, comp_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   vis_reg, vis_next;
    logic [PLANE_COUNT-1:0] mask_reg, mask_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_visible_reg, m_visible_next;
    logic [2:0]             m_fail_reg, m_fail_next;
    logic [5:0]             m_mask_reg, m_mask_next;

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_visible         = m_visible_reg;
    assign m_failing_plane   = m_fail_reg;
    assign m_degenerate_mask = m_mask_reg;

    always_comb begin
        state_next     = state_reg;
        plane_next     = plane_reg;
        comp_next      = comp_reg;
        iter_next      = iter_reg;
        vis_next       = vis_reg;
        mask_next      = mask_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_visible_next = m_visible_reg;
        m_fail_next    = m_fail_reg;
        m_mask_next    = m_mask_reg;
        cmd            = '0;
        cmd.plane      = plane_reg;
        cmd.comp       = comp_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    plane_next  = '0;
                    mask_next   = '0;
                    vis_next    = 1'b0;
                    state_next  = s_kind ? ST_CULL_MUL : ST_RB_RAW;
                end
            end
            ST_CULL_MUL: begin
                cmd.cull_mul = 1'b1;
                state_next   = ST_CULL_ACC;
            end
            ST_CULL_ACC: begin
                if (status.reject) begin
                    vis_next   = 1'b0;
                    state_next = ST_FIN;
                end else if (plane_reg == LAST_PLANE) begin
                    vis_next   = 1'b1;
                    plane_next = '0;
                    state_next = ST_FIN;
                end else begin
                    plane_next = plane_reg + 1'b1;
                    state_next = ST_CULL_MUL;
                end
            end
            ST_RB_RAW: begin
                cmd.raw_load = 1'b1;
                state_next   = ST_RB_SUM;
            end
            ST_RB_SUM: begin
                if (status.sum_zero) begin
                    cmd.store_zero        = 1'b1;
                    mask_next[plane_reg]  = 1'b1;
                    if (plane_reg == LAST_PLANE) begin
                        plane_next = '0;
                        state_next = ST_FIN;
                    end else begin
                        plane_next = plane_reg + 1'b1;
                        state_next = ST_RB_RAW;
                    end
                end else begin
                    cmd.sqrt_init = 1'b1;
                    iter_next     = '0;
                    state_next    = ST_RB_SQRT;
                end
            end
            ST_RB_SQRT: begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(SQRT_STEPS - 1)) begin
                    comp_next  = '0;
                    state_next = ST_RB_DIVI;
                end
            end
            ST_RB_DIVI: begin
                cmd.div_init = 1'b1;
                iter_next    = '0;
                state_next   = ST_RB_DIV;
            end
            ST_RB_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1)) begin
                    state_next = ST_RB_WR;
                end
            end
            ST_RB_WR: begin
                cmd.store_word = 1'b1;
                if (comp_reg != LAST_COMP) begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_RB_DIVI;
                end else if (plane_reg == LAST_PLANE) begin
                    plane_next = '0;
                    state_next = ST_FIN;
                end else begin
                    plane_next = plane_reg + 1'b1;
                    state_next = ST_RB_RAW;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_visible_next = vis_reg;
                    m_fail_next    = vis_reg ? 3'd0 : plane_reg;
                    m_mask_next    = mask_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            plane_reg   <= '0;
            comp_reg    <= '0;
            iter_reg    <= '0;
            vis_reg     <= 1'b0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            plane_reg   <= plane_next;
            comp_reg    <= comp_next;
            iter_reg    <= iter_next;
            vis_reg     <= vis_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_visible_reg <= m_visible_next;
        m_fail_reg    <= m_fail_next;
        m_mask_reg    <= m_mask_next;
    end

endmodule

@@ rtl/core/sphere_frustum_cull.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Bounding-sphere view-frustum culling against six planes extracted from a
// projection-view matrix.
// ----------------------------------------------------------------------------
// The configuration channel writes the four matrix columns (cfg_index 0..3);
// it is always ready. An input transaction with s_kind low rebuilds the six
// normalized planes from the matrix; one with s_kind high tests a sphere.
// Each input transaction yields exactly one output transaction.
// A cull tests the planes in turn, each with a multiply step and then a
// sum-and-compare step, stopping at the first plane that rejects; the
// result register is then loaded. A rebuild runs a bit-serial square root
// and four bit-serial divides per plane, or clears and flags a plane whose
// sum of squares is zero. One transaction is in flight at a time; s_ready is
// high only while the block is idle.
// If the receiver stalls, the result is held in the output register and the
// block waits before returning to idle. Reset clears the matrix and the
// plane store, so a cull before any rebuild reports the sphere visible.
// ----------------------------------------------------------------------------
module sphere_frustum_cull import sfc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_center_x,
    input  logic signed [31:0] s_center_y,
    input  logic signed [31:0] s_center_z,
    input  logic [30:0]        s_sphere_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic [2:0]         m_failing_plane,
    output logic [5:0]         m_degenerate_mask
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sfc_controller u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_visible         (m_visible),
        .m_failing_plane   (m_failing_plane),
        .m_degenerate_mask (m_degenerate_mask),
        .status            (status),
        .cmd               (cmd)
    );

    sfc_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_center_x      (s_center_x),
        .s_center_y      (s_center_y),
        .s_center_z      (s_center_z),
        .s_sphere_radius (s_sphere_radius),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

@@ rtl/core/sfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks of the sphere culling block, bound to its top level.
// ----------------------------------------------------------------------------
`include "sphere_frustum_cull_assert.svh"

module sfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_visible,
    input logic [2:0]  m_failing_plane,
    input logic [5:0]  m_degenerate_mask
);

    `SFC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `SFC_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "accepted while busy")
    `SFC_ASSERT_SAME(a_visible_clean, m_valid && m_visible, m_failing_plane == 3'd0 && m_degenerate_mask == 6'd0, "visible result carries plane or mask")
    `SFC_ASSERT_SAME(a_plane_range, m_valid, m_failing_plane <= 3'd5, "failing plane out of range")

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (.*);
